@@ rtl/core/fhc_pkg.sv @@
// Shared types and constants for the float32/half converter.
package fhc_pkg;

    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int F_EXP_W  = 8;
    localparam int F_MAN_W  = 23;
    localparam int H_EXP_W  = 5;
    localparam int H_MAN_W  = 10;
    localparam int H_LZ_W   = 4;

    // float exponent bias difference: 127 - 15
    localparam logic [F_EXP_W-1:0] BIAS_DIFF    = 8'd112;
    localparam logic [F_EXP_W-1:0] F_EXP_MAX    = 8'hff;
    localparam logic [F_EXP_W-1:0] F_EXP_OVF    = 8'd142;
    localparam logic [H_EXP_W-1:0] H_EXP_MAX    = 5'h1f;
    localparam logic [F_EXP_W-1:0] SUBN_EXP_OFS = 8'd103;

    typedef enum logic {
        CMD_TO_HALF  = 1'b0,
        CMD_TO_FLOAT = 1'b1
    } t_cmd;

endpackage

@@ rtl/core/fhc_to_half.sv @@
// Float32 to half conversion: truncating, saturating to Inf, flushing to zero.
module fhc_to_half (
    input  logic [fhc_pkg::WORD_W-1:0] i_float,
    output logic [fhc_pkg::HALF_W-1:0] o_half
);
    import fhc_pkg::*;

    logic                sign;
    logic [F_EXP_W-1:0]  bexp;
    logic [F_MAN_W-1:0]  mant;
    logic [F_EXP_W-1:0]  hexp_full;

    assign sign      = i_float[WORD_W-1];
    assign bexp      = i_float[WORD_W-2 -: F_EXP_W];
    assign mant      = i_float[F_MAN_W-1:0];
    assign hexp_full = bexp - BIAS_DIFF;

    always_comb begin
        if (bexp == F_EXP_MAX) begin
            // Inf/NaN keeps the low mantissa bits
            o_half = {sign, H_EXP_MAX, mant[H_MAN_W-1:0]};
        end else if (bexp > F_EXP_OVF) begin
            o_half = {sign, H_EXP_MAX, {H_MAN_W{1'b0}}};
        end else if (bexp > BIAS_DIFF) begin
            o_half = {sign, hexp_full[H_EXP_W-1:0], mant[F_MAN_W-1 -: H_MAN_W]};
        end else begin
            o_half = {sign, {(HALF_W-1){1'b0}}};
        end
    end

endmodule

@@ rtl/core/fhc_to_float.sv @@
// Half to float32 conversion, exact for all half patterns.
module fhc_to_float (
    input  logic [fhc_pkg::HALF_W-1:0] i_half,
    output logic [fhc_pkg::WORD_W-1:0] o_float
);
    import fhc_pkg::*;

    logic                sign;
    logic [H_EXP_W-1:0]  hexp;
    logic [H_MAN_W-1:0]  mant;
    logic [H_LZ_W-1:0]   lead_pos;
    logic [H_MAN_W-1:0]  norm;
    logic [F_EXP_W-1:0]  subn_exp;
    logic [F_EXP_W-1:0]  norm_exp;

    assign sign = i_half[HALF_W-1];
    assign hexp = i_half[HALF_W-2 -: H_EXP_W];
    assign mant = i_half[H_MAN_W-1:0];

    // position of the leading one in a subnormal mantissa
    always_comb begin
        lead_pos = '0;
        for (int i = 0; i < H_MAN_W; i++) begin
            if (mant[i]) begin
                lead_pos = H_LZ_W'(i);
            end
        end
    end

    assign norm     = mant << (H_LZ_W'(H_MAN_W - 1) - lead_pos);
    assign subn_exp = F_EXP_W'(lead_pos) + SUBN_EXP_OFS;
    assign norm_exp = F_EXP_W'(hexp) + BIAS_DIFF;

    always_comb begin
        if (hexp == '0) begin
            if (mant == '0) begin
                o_float = {sign, {(WORD_W-1){1'b0}}};
            end else begin
                // leading one becomes hidden; remaining bits go to the top
                o_float = {sign, subn_exp, norm[H_MAN_W-2:0],
                           {(F_MAN_W-H_MAN_W+1){1'b0}}};
            end
        end else if (hexp == H_EXP_MAX) begin
            o_float = {sign, F_EXP_MAX, {(F_MAN_W-H_MAN_W){1'b0}}, mant};
        end else begin
            o_float = {sign, norm_exp, mant, {(F_MAN_W-H_MAN_W){1'b0}}};
        end
    end

endmodule

@@ rtl/core/float32_half_converter_unit.sv @@
// Top level: input register, conversion logic, result register.
// The accepted input beat waits in the input register and moves into the result
// register when that is free; o_out_valid then shows the result beat.
// Throughput: one beat per cycle unless the receiver stalls; input and result
// registers each advance whenever the stage after them is free or draining.
// Reset (synchronous, active low) clears both stage valid flags; payload
// registers are not reset.
module float32_half_converter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [fhc_pkg::WORD_W-1:0]  i_operand_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [fhc_pkg::WORD_W-1:0]  o_result_word
);
    import fhc_pkg::*;

    logic                r_in_v;
    logic                n_in_v;
    t_cmd                r_cmd;
    logic [WORD_W-1:0]   r_word;
    logic                r_out_v;
    logic                n_out_v;
    logic [WORD_W-1:0]   r_result;
    logic [WORD_W-1:0]   n_result;
    logic                out_free;
    logic [HALF_W-1:0]   half_res;
    logic [WORD_W-1:0]   float_res;

    fhc_to_half u_to_half (
        .i_float (r_word),
        .o_half  (half_res)
    );

    fhc_to_float u_to_float (
        .i_half  (r_word[HALF_W-1:0]),
        .o_float (float_res)
    );

    assign out_free   = !r_out_v || i_out_ready;
    assign o_in_ready = !r_in_v || out_free;

    always_comb begin
        unique case (r_cmd)
            CMD_TO_HALF:  n_result = {{(WORD_W-HALF_W){1'b0}}, half_res};
            CMD_TO_FLOAT: n_result = float_res;
            default:      n_result = float_res;
        endcase
    end

    always_comb begin
        n_in_v = r_in_v;
        if (o_in_ready) begin
            n_in_v = i_in_valid;
        end
        n_out_v = r_out_v;
        if (out_free) begin
            n_out_v = r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= t_cmd'(i_command);
            r_word <= i_operand_word;
        end
        if (out_free && r_in_v) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_result_word = r_result;

endmodule

@@ tb/float32_half_converter_unit_tb.sv @@
// Self-checking testbench for the float32/half converter unit.
`timescale 1ns / 100ps

module float32_half_converter_unit_tb;
    import fhc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_command      = CMD_TO_HALF;
    logic [WORD_W-1:0]    i_operand_word = '0;
    logic                 i_out_ready    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [WORD_W-1:0]    o_result_word;

    logic [WORD_W-1:0]    expected_words[$];
    logic [WORD_W-1:0]    front_word;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_request   = 0;
    int                   hold_left      = 0;
    int                   quiet_cycles   = 0;
    int                   fail_count     = 0;
    int                   results_seen   = 0;
    int                   to_half_beats  = 0;
    int                   to_float_beats = 0;

    float32_half_converter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_operand_word (i_operand_word),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_word  (o_result_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Expected conversion of one input word.
    function automatic logic [WORD_W-1:0] convert_word(input t_cmd cmd,
                                                       input logic [WORD_W-1:0] word);
        logic        sign;
        logic [7:0]  bexp;
        logic [22:0] fman;
        logic [4:0]  hexp;
        logic [9:0]  hman;
        logic [22:0] frac;
        int          msb;
        if (cmd == CMD_TO_HALF) begin
            sign = word[31];
            bexp = word[30:23];
            fman = word[22:0];
            if (bexp == 8'hff)
                return {16'h0, sign, 5'h1f, fman[9:0]};
            if (bexp > 8'd142)
                return {16'h0, sign, 5'h1f, 10'h0};
            if (bexp > 8'd112)
                return {16'h0, sign, 5'(bexp - 8'd112), fman[22:13]};
            return {16'h0, sign, 15'h0};
        end
        sign = word[15];
        hexp = word[14:10];
        hman = word[9:0];
        if (hexp == 5'h0) begin
            if (hman == 10'h0)
                return {sign, 31'h0};
            msb = 9;
            while (!hman[msb])
                msb--;
            // leading one drops out of the 23-bit fraction
            frac = {13'h0, hman} << (23 - msb);
            return {sign, 8'(msb + 103), frac};
        end
        if (hexp == 5'h1f)
            return {sign, 8'hff, 13'h0, hman};
        return {sign, 8'(hexp + 5'd0) + 8'd112, hman, 13'h0};
    endfunction

    // Offer one beat, with random idle cycles ahead of it.
    task automatic send_beat(input t_cmd cmd, input logic [WORD_W-1:0] word);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_operand_word <= word;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_words.push_back(convert_word(cmd, word));
        if (cmd == CMD_TO_HALF)
            to_half_beats++;
        else
            to_float_beats++;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Biased toward exponent boundaries and the special classes.
    task automatic random_item(output t_cmd cmd, output logic [WORD_W-1:0] word);
        logic [7:0] bexp;
        logic [4:0] hexp;
        int         pick;
        pick = $urandom_range(9);
        word = $urandom;
        if (pick < 2) begin
            cmd = t_cmd'($urandom_range(1));
        end else if (pick < 6) begin
            cmd = CMD_TO_HALF;
            case ($urandom_range(3))
                0: bexp = 8'($urandom_range(100, 150));
                1: begin
                    case ($urandom_range(9))
                        0: bexp = 8'd0;
                        1: bexp = 8'd1;
                        2: bexp = 8'd111;
                        3: bexp = 8'd112;
                        4: bexp = 8'd113;
                        5: bexp = 8'd141;
                        6: bexp = 8'd142;
                        7: bexp = 8'd143;
                        8: bexp = 8'd254;
                        default: bexp = 8'hff;
                    endcase
                end
                2: bexp = 8'hff;
                default: bexp = 8'($urandom);
            endcase
            word[30:23] = bexp;
            case ($urandom_range(3))
                0: word[22:0] = '0;
                1: word[22:0] = '1;
                2: word[9:0]  = '0;
                default: ;
            endcase
        end else begin
            cmd = CMD_TO_FLOAT;
            case ($urandom_range(3))
                0: hexp = 5'h0;
                1: hexp = 5'h1f;
                default: hexp = 5'($urandom);
            endcase
            word[14:10] = hexp;
            // vary the leading-one position of subnormals
            if (hexp == 5'h0)
                word[9:0] = word[9:0] >> $urandom_range(9);
        end
    endtask

    task automatic test_directed_corners();
        send_beat(CMD_TO_HALF,  32'h0000_0000);   // +0
        send_beat(CMD_TO_HALF,  32'h8000_0000);   // -0
        send_beat(CMD_TO_HALF,  32'h0000_0001);   // float subnormal flushes
        send_beat(CMD_TO_HALF,  32'h807f_ffff);   // largest negative subnormal
        send_beat(CMD_TO_HALF,  32'h3800_0000);   // E = -15, just below range
        send_beat(CMD_TO_HALF,  32'h38ff_ffff);   // E = -14, lowest half normal
        send_beat(CMD_TO_HALF,  32'h477f_ffff);   // E = 15, truncates to max half
        send_beat(CMD_TO_HALF,  32'h4780_0000);   // E = 16, overflow
        send_beat(CMD_TO_HALF,  32'hff7f_ffff);   // max float, negative
        send_beat(CMD_TO_HALF,  32'h7f80_0000);   // +inf
        send_beat(CMD_TO_HALF,  32'h7fc0_0000);   // NaN with zero low bits -> inf
        send_beat(CMD_TO_HALF,  32'hff80_03ff);   // NaN keeps low ten bits
        send_beat(CMD_TO_FLOAT, 32'h0000_0000);
        send_beat(CMD_TO_FLOAT, 32'h0000_8000);
        send_beat(CMD_TO_FLOAT, 32'h0000_0001);   // smallest subnormal
        send_beat(CMD_TO_FLOAT, 32'h0000_03ff);   // largest subnormal
        send_beat(CMD_TO_FLOAT, 32'h0000_8200);
        send_beat(CMD_TO_FLOAT, 32'h0000_0400);   // smallest normal
        send_beat(CMD_TO_FLOAT, 32'h0000_7bff);   // largest normal
        send_beat(CMD_TO_FLOAT, 32'h0000_7c00);
        send_beat(CMD_TO_FLOAT, 32'h0000_fc00);
        send_beat(CMD_TO_FLOAT, 32'h0000_7e00);   // quiet NaN
        send_beat(CMD_TO_FLOAT, 32'h0000_fc01);
        send_beat(CMD_TO_FLOAT, 32'hffff_3c00);   // upper bits ignored
        wait_drained();
    endtask

    task automatic test_random_traffic(input int beats, input int idle_pct,
                                       input int stall_pct);
        t_cmd              cmd;
        logic [WORD_W-1:0] word;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (beats) begin
            random_item(cmd, word);
            send_beat(cmd, word);
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the pipe fills.
    task automatic test_output_holdoff();
        t_cmd              cmd;
        logic [WORD_W-1:0] word;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (60) begin
            random_item(cmd, word);
            send_beat(cmd, word);
        end
        wait_drained();
    endtask

    // Sender stops after short bursts until all results are back.
    task automatic test_sender_pause();
        t_cmd              cmd;
        logic [WORD_W-1:0] word;
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (5) begin
            repeat (4) begin
                random_item(cmd, word);
                send_beat(cmd, word);
            end
            wait_drained();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_words.size() == 0) begin
                if (fail_count < REPORT_MAX)
                    $display("ERROR: result beat %h with nothing expected", o_result_word);
                fail_count++;
            end else begin
                front_word = expected_words.pop_front();
                if (o_result_word !== front_word) begin
                    if (fail_count < REPORT_MAX)
                        $display("ERROR: result_word expected %h got %h",
                                 front_word, o_result_word);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_traffic(430, 0, 0);
        test_random_traffic(430, 76, 0);
        test_random_traffic(430, 0, 76);
        test_random_traffic(430, 30, 30);
        test_output_holdoff();
        test_sender_pause();

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d float-to-half and %0d half-to-float beats, %0d results checked",
                 to_half_beats, to_float_beats, results_seen);
        $display("Flow control: free-running, sender gaps, receiver stalls, long hold-off");
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count,
                     expected_words.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
